FILE: rtl/scib_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scib_pkg
// Shared types, constants and the sort key function of the sorted card
// insert buffer.
// ----------------------------------------------------------------------------
package scib_pkg;

   // default depth of the card store
   localparam int ENTRIES_DEFAULT = 16;

   // field widths
   localparam int SUIT_W  = 2;
   localparam int RANK_W  = 7;
   localparam int ENTRY_W = SUIT_W + RANK_W;
   localparam int KEY_W   = 10;

   // suit bases of the sort key
   localparam logic [KEY_W-1:0] BASE_S = KEY_W'(100);
   localparam logic [KEY_W-1:0] BASE_D = KEY_W'(200);
   localparam logic [KEY_W-1:0] BASE_H = KEY_W'(300);
   localparam logic [KEY_W-1:0] BASE_C = KEY_W'(400);

   // suit codes
   localparam logic [SUIT_W-1:0] SUIT_S = 2'd0;
   localparam logic [SUIT_W-1:0] SUIT_D = 2'd1;
   localparam logic [SUIT_W-1:0] SUIT_H = 2'd2;
   localparam logic [SUIT_W-1:0] SUIT_C = 2'd3;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // sort key of one stored entry {suit, rank}
   function automatic logic [KEY_W-1:0] key_of(input logic [ENTRY_W-1:0] entry);
      logic [KEY_W-1:0] base;
      unique case (entry[ENTRY_W-1:RANK_W])
         SUIT_S:  base = BASE_S;
         SUIT_D:  base = BASE_D;
         SUIT_H:  base = BASE_H;
         SUIT_C:  base = BASE_C;
         default: base = BASE_S;
      endcase
      return base + KEY_W'(entry[RANK_W-1:0]);
   endfunction

endpackage

FILE: rtl/scib_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scib_store
// Card store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scib_store #(
   parameter int DEPTH = scib_pkg::ENTRIES_DEFAULT,
   parameter int AW    = 4
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [scib_pkg::ENTRY_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [scib_pkg::ENTRY_W-1:0] rd_data
);

   logic [scib_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [scib_pkg::ENTRY_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sorted_card_insert_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_card_insert_buffer
// Keeps up to ENTRIES cards in ascending key order (suit base plus rank),
// inserts each new card after equal keys unless full; emits the whole order.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_card_suit, req_card_rank        start high, busy low
//  result    rsp_out_suit, rsp_out_rank,         rsp_valid, one cycle each
//            rsp_is_last, rsp_overflow
//
//  one pass walks the store front to rear through its single read port, one
//  entry a cycle, writing the shifted entries back as it goes.
//  an item keeps busy high until the merge stage has taken the last of the
//  stored cards after the insert; results run back to back, each passing
//  the read stage, the registered store read and the result registers.
//  reset empties the store at once; no clearing pass.
//  the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module sorted_card_insert_buffer #(
   parameter int ENTRIES = scib_pkg::ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [scib_pkg::SUIT_W-1:0] req_card_suit,
   input  logic [scib_pkg::RANK_W-1:0] req_card_rank,
   output logic                        rsp_valid,
   output logic [scib_pkg::SUIT_W-1:0] rsp_out_suit,
   output logic [scib_pkg::RANK_W-1:0] rsp_out_rank,
   output logic                        rsp_is_last,
   output logic                        rsp_overflow
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = scib_pkg::ENTRY_W;

   // control registers
   scib_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          proc_vld_ff, proc_vld_in;
   logic          ins_done_ff, ins_done_in;
   logic          drop_ff, drop_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CW-1:0] proc_idx_ff, proc_idx_in;
   logic [EW-1:0] card_ff, card_in;
   logic [EW-1:0] hold_ff, hold_in;
   logic [EW-1:0] rsp_entry_ff, rsp_entry_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // store ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic          rd_en;
   logic [EW-1:0] rd_data;

   logic          proc_last;
   logic          card_first;

   scib_store #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scib_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rd_idx_ff    <= '0;
         proc_vld_ff  <= 1'b0;
         ins_done_ff  <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rd_idx_ff    <= rd_idx_in;
         proc_vld_ff  <= proc_vld_in;
         ins_done_ff  <= ins_done_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      proc_idx_ff  <= proc_idx_in;
      card_ff      <= card_in;
      hold_ff      <= hold_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // position being processed is the rear of the run
   assign proc_last  = (proc_idx_ff == total_ff - CW'(1));
   // new card goes before the entry read at this position
   assign card_first = scib_pkg::key_of(card_ff) < scib_pkg::key_of(rd_data);

   // sequencer: read stage, then merge stage that writes back and emits
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rd_idx_in    = rd_idx_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = rd_idx_ff;
      ins_done_in  = ins_done_ff;
      drop_in      = drop_ff;
      card_in      = card_ff;
      hold_in      = hold_ff;
      rsp_valid_in = 1'b0;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = proc_idx_ff[AW-1:0];
      wr_data      = card_ff;

      unique case (state_ff)
         scib_pkg::ST_IDLE: begin
            if (start) begin
               state_in    = scib_pkg::ST_RUN;
               card_in     = {req_card_suit, req_card_rank};
               rd_idx_in   = '0;
               ins_done_in = 1'b0;
               drop_in     = (count_ff == CW'(ENTRIES));
               total_in    = (count_ff == CW'(ENTRIES)) ? count_ff : count_ff + CW'(1);
            end
         end
         scib_pkg::ST_RUN: begin
            // read stage
            if (rd_idx_ff < total_ff) begin
               rd_en       = 1'b1;
               proc_vld_in = 1'b1;
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
            // merge stage
            if (proc_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = proc_last;
               rsp_ovf_in   = drop_ff;
               priority if (drop_ff) begin
                  rsp_entry_in = rd_data;
               end else if (ins_done_ff) begin
                  wr_en        = 1'b1;
                  wr_data      = hold_ff;
                  rsp_entry_in = hold_ff;
                  hold_in      = rd_data;
               end else if (proc_last || card_first) begin
                  wr_en        = 1'b1;
                  wr_data      = card_ff;
                  rsp_entry_in = card_ff;
                  hold_in      = rd_data;
                  ins_done_in  = 1'b1;
               end else begin
                  rsp_entry_in = rd_data;
               end
               if (proc_last) begin
                  state_in = scib_pkg::ST_IDLE;
                  count_in = total_ff;
               end
            end
         end
         default: begin
            state_in = scib_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   assign busy         = (state_ff != scib_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_suit = rsp_entry_ff[EW-1:scib_pkg::RANK_W];
   assign rsp_out_rank = rsp_entry_ff[scib_pkg::RANK_W-1:0];
   assign rsp_is_last  = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

FILE: rtl/scib_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scib_checker
// Port-level checks on request acceptance and the result run.
// ----------------------------------------------------------------------------
module scib_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_is_last
);

   // a taken request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // results only come out of a pass in progress
   a_rsp_in_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside a pass");

   // a run has no gaps before its last result
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_last) |=> rsp_valid)
      else $error("gap inside a result run");

   // a run ends with its last result
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |=> !rsp_valid)
      else $error("result right after the last of a run");

endmodule

bind sorted_card_insert_buffer scib_checker u_scib_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_is_last (rsp_is_last)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted card insert buffer. A driver presents
// card requests from a queue, a monitor keeps a model of the sorted store,
// predicts the full front-to-rear order emitted after every request and
// compares each emitted entry field by field. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH   = scib_pkg::ENTRIES_DEFAULT;
   localparam int SUIT_W  = scib_pkg::SUIT_W;
   localparam int RANK_W  = scib_pkg::RANK_W;
   localparam int ENTRY_W = scib_pkg::ENTRY_W;
   localparam int N_RANDOM = 200;

   typedef logic [ENTRY_W-1:0] card_type;

   // one pending request with the idle cycles that precede it
   typedef struct packed {
      logic [SUIT_W-1:0] suit;
      logic [RANK_W-1:0] rank;
      logic [7:0]        gap;
   } card_req_type;

   // one expected entry of an emitted order
   typedef struct packed {
      logic [SUIT_W-1:0] suit;
      logic [RANK_W-1:0] rank;
      logic              last;
      logic              dropped;
   } order_entry_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [SUIT_W-1:0] req_card_suit;
   logic [RANK_W-1:0] req_card_rank;
   logic              rsp_valid;
   logic [SUIT_W-1:0] rsp_out_suit;
   logic [RANK_W-1:0] rsp_out_rank;
   logic              rsp_is_last;
   logic              rsp_overflow;

   card_req_type    pending_cards[$];
   order_entry_type expected_order[$];
   card_type        card_store[$];

   bit req_holding;
   bit req_taken;
   int gap_left;
   int fail_count;
   int cards_taken;
   int cards_dropped;
   int entries_checked;
   int peak_depth;

   sorted_card_insert_buffer #(
      .ENTRIES(DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_card_suit(req_card_suit),
      .req_card_rank(req_card_rank),
      .rsp_valid    (rsp_valid),
      .rsp_out_suit (rsp_out_suit),
      .rsp_out_rank (rsp_out_rank),
      .rsp_is_last  (rsp_is_last),
      .rsp_overflow (rsp_overflow)
   );

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sort key: suit base (code + 1) * 100 plus rank
   function automatic int card_sort_key(input card_type card);
      return (int'(card[ENTRY_W-1:RANK_W]) + 1) * 100 + int'(card[RANK_W-1:0]);
   endfunction

   // insert one card into the store model and queue the order it emits
   task automatic predict_insert(input logic [SUIT_W-1:0] suit,
                                 input logic [RANK_W-1:0] rank);
      card_type        card;
      int              key;
      int              pos;
      bit              full;
      order_entry_type entry;
      card = {suit, rank};
      key  = card_sort_key(card);
      full = (card_store.size() >= DEPTH);
      if (!full) begin
         // first stored key strictly above the new one; equal keys stay ahead
         pos = card_store.size();
         for (int i = 0; i < card_store.size(); i++) begin
            if (key < card_sort_key(card_store[i])) begin
               pos = i;
               break;
            end
         end
         card_store.insert(pos, card);
      end else begin
         cards_dropped++;
      end
      if (card_store.size() > peak_depth) peak_depth = card_store.size();
      for (int i = 0; i < card_store.size(); i++) begin
         entry.suit    = card_store[i][ENTRY_W-1:RANK_W];
         entry.rank    = card_store[i][RANK_W-1:0];
         entry.last    = (i == card_store.size() - 1);
         entry.dropped = full;
         expected_order.push_back(entry);
      end
   endtask

   task automatic add_card(input logic [SUIT_W-1:0] suit,
                           input logic [RANK_W-1:0] rank,
                           input int gap);
      card_req_type req;
      req.suit = suit;
      req.rank = rank;
      req.gap  = 8'(gap);
      pending_cards.push_back(req);
   endtask

   // idle cycles ahead of a request, geometric with the given idle percent
   function automatic int draw_gap(input int idle_pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      return gap;
   endfunction

   // driver: requests change at the falling edge
   always @(negedge clock) begin
      card_req_type next_req;
      if (!reset) begin
         if (req_holding && req_taken) req_holding = 1'b0;
         if (!req_holding && pending_cards.size() != 0 && gap_left < 0)
            gap_left = pending_cards[0].gap;
         if (!req_holding && pending_cards.size() != 0 && gap_left == 0) begin
            next_req = pending_cards.pop_front();
            req_card_suit <= next_req.suit;
            req_card_rank <= next_req.rank;
            req_holding = 1'b1;
            gap_left    = -1;
         end else if (!req_holding) begin
            // idle: fields carry noise that the block must ignore
            if (gap_left > 0) gap_left--;
            req_card_suit <= SUIT_W'($urandom);
            req_card_rank <= RANK_W'($urandom);
         end
         start <= req_holding;
      end
   end

   // monitor: take requests and check emitted entries at the rising edge
   always @(posedge clock) begin
      order_entry_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy) begin
            cards_taken++;
            predict_insert(req_card_suit, req_card_rank);
         end
         if (rsp_valid === 1'b1) begin
            if (expected_order.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected entry suit=%0d rank=%0d last=%0b ovf=%0b",
                           $realtime, rsp_out_suit, rsp_out_rank, rsp_is_last,
                           rsp_overflow);
            end else begin
               want = expected_order.pop_front();
               entries_checked++;
               if (rsp_out_suit !== want.suit || rsp_out_rank !== want.rank ||
                   rsp_is_last !== want.last || rsp_overflow !== want.dropped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t mismatch exp suit=%0d rank=%0d last=%0b ovf=%0b %s",
                              $realtime, want.suit, want.rank, want.last,
                              want.dropped, "got");
                  if (fail_count <= 10)
                     $display("      got suit=%0d rank=%0d last=%0b ovf=%0b",
                              rsp_out_suit, rsp_out_rank, rsp_is_last, rsp_overflow);
               end
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int idle_pct;
      int rank_pick;
      logic [RANK_W-1:0] rank_val;
      reset         = 1'b1;
      start         = 1'b0;
      req_card_suit = '0;
      req_card_rank = '0;
      req_holding   = 1'b0;
      gap_left      = -1;

      // directed: empty store, extremes, equal keys, ranks past 99
      add_card(scib_pkg::SUIT_S, 7'd0,   0);
      add_card(scib_pkg::SUIT_C, 7'd127, 0);
      add_card(scib_pkg::SUIT_D, 7'd0,   0);
      add_card(scib_pkg::SUIT_S, 7'd100, 2);
      add_card(scib_pkg::SUIT_S, 7'd127, 0);
      add_card(scib_pkg::SUIT_D, 7'd0,   1);
      add_card(scib_pkg::SUIT_H, 7'd50,  0);
      add_card(scib_pkg::SUIT_H, 7'd50,  0);
      add_card(scib_pkg::SUIT_S, 7'd0,   3);
      add_card(scib_pkg::SUIT_C, 7'd99,  0);
      add_card(scib_pkg::SUIT_H, 7'd127, 0);
      add_card(scib_pkg::SUIT_D, 7'd85,  0);

      // random: phases of sender idling, keys often colliding
      for (int n = 0; n < N_RANDOM; n++) begin
         case (n / 50)
            0:       idle_pct = 0;
            1:       idle_pct = 54;
            2:       idle_pct = 33;
            default: idle_pct = 0;
         endcase
         rank_pick = $urandom_range(9);
         if (rank_pick < 2)      rank_val = RANK_W'($urandom_range(127, 100));
         else if (rank_pick < 5) rank_val = RANK_W'($urandom_range(3) * 33);
         else                    rank_val = RANK_W'($urandom_range(99));
         add_card(SUIT_W'($urandom), rank_val, draw_gap(idle_pct));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (pending_cards.size() != 0 || req_holding || expected_order.size() != 0);
      repeat (2 * DEPTH + 8) @(posedge clock);

      if (expected_order.size() != 0) begin
         fail_count++;
         $display("%0d expected entries never emitted", expected_order.size());
      end
      $display("%0d cards requested, %0d dropped on a full store, peak depth %0d",
               cards_taken, cards_dropped, peak_depth);
      $display("%0d emitted entries compared, %0d failures", entries_checked, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

endmodule
